/* hdl/rqs_pkg.sv */
`timescale 1ns / 1ps
// rqs_pkg: shared constants and types for the record quicksort block
// no dependencies
package rqs_pkg;
  localparam int unsigned MaxRecords = 64;
  localparam int unsigned AddrW = $clog2(MaxRecords);
  localparam int unsigned CntW = $clog2(MaxRecords + 1);
  localparam int unsigned RecW = 32;
  localparam int unsigned StkW = 2 * AddrW;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_POP,
    ST_POPW,
    ST_PIV,
    ST_RDI,
    ST_CMP,
    ST_SWN,
    ST_FIN,
    ST_FINW,
    ST_PUSH,
    ST_ORD,
    ST_OUT
  } state_t;
endpackage

/* hdl/rqs_ram.sv */
`timescale 1ns / 1ps
// rqs_ram: single-port synchronous ram with registered read
// no dependencies
module rqs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

/* hdl/record_quicksort_by_key_top.sv */
`timescale 1ns / 1ps
// record_quicksort_by_key_top: loads records, sorts by key with lomuto quicksort, streams out
// depends on rqs_pkg and rqs_ram
//
// channel | direction | tdata fields (low bit up)     | tuser / tlast
// in_     | slave     | key[15:0], tag[31:16]         | tlast = last_in
// out_    | master    | out_key[15:0], out_tag[31:16] | tuser = overflow, tlast = last_out
// cfg_    | slave     | descending                    | -
//
// loading accepts one record per cycle; sorting runs on one single-port record ram
// and one stack ram; on output the next record is read only after the previous one is taken.
// input is held off from the last record until the run is taken; output stalls hold the walk.
// reset is synchronous; stored records need no clearing.
module record_quicksort_by_key_top
  import rqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // key, tag
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_key, out_tag
  output logic        out_tuser,  // overflow
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  state_t state_r, state_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt, desc_r;
  logic [AddrW-1:0] lo_r, lo_nxt, hi_r, hi_nxt, nx_r, nx_nxt, i_r, i_nxt;
  logic [AddrW:0]   sp_r, sp_nxt;
  logic [15:0]      piv_r, piv_nxt;
  logic [RecW-1:0]  hold_r, hold_nxt;
  logic             pl_r, pl_nxt, ph_r, ph_nxt;
  logic             ov_r, ov_nxt, ol_r, ol_nxt;
  logic [RecW-1:0]  od_r, od_nxt;

  logic             rwe;
  logic [AddrW-1:0] raddr;
  logic [RecW-1:0]  rwd, rrd;
  logic             swe;
  logic [AddrW-1:0] saddr;
  logic [StkW-1:0]  swd, srd;
  logic             low_side;
  logic signed [15:0] ki, kp;

  rqs_ram #(.Width(RecW), .Depth(MaxRecords)) u_rec (
    .clk(clk), .we(rwe), .addr(raddr), .wdata(rwd), .rdata(rrd));
  rqs_ram #(.Width(StkW), .Depth(MaxRecords)) u_stk (
    .clk(clk), .we(swe), .addr(saddr), .wdata(swd), .rdata(srd));

  assign ki = rrd[15:0];
  assign kp = piv_r;
  assign low_side = desc_r ? (ki >= kp) : (ki <= kp);
  assign in_tready = (state_r == ST_LOAD);
  assign cfg_ready = 1'b1;
  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ovf_r;
  assign out_tlast = ol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      desc_r <= 1'b0;
      ov_r <= 1'b0;
      sp_r <= '0;
      ph_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      ov_r <= ov_nxt;
      sp_r <= sp_nxt;
      ph_r <= ph_nxt;
      if (cfg_valid) begin
        desc_r <= cfg_data;
      end
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; nx_r <= nx_nxt; i_r <= i_nxt;
    piv_r <= piv_nxt; hold_r <= hold_nxt; pl_r <= pl_nxt;
    ol_r <= ol_nxt; od_r <= od_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; ovf_nxt = ovf_r; sp_nxt = sp_r;
    lo_nxt = lo_r; hi_nxt = hi_r; nx_nxt = nx_r; i_nxt = i_r;
    piv_nxt = piv_r; hold_nxt = hold_r; pl_nxt = pl_r; ph_nxt = ph_r;
    ov_nxt = ov_r; ol_nxt = ol_r; od_nxt = od_r;
    rwe = 1'b0; raddr = i_r; rwd = rrd;
    swe = 1'b0; saddr = sp_r[AddrW-1:0]; swd = {lo_r, hi_r};
    unique case (state_r)
      ST_LOAD: begin
        raddr = cnt_r[AddrW-1:0];
        rwd = in_tdata;
        if (in_tvalid) begin
          if (cnt_r < CntW'(MaxRecords)) begin
            rwe = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            if (cnt_nxt >= CntW'(2)) begin
              lo_nxt = '0;
              hi_nxt = AddrW'(cnt_nxt - 1'b1);
              state_nxt = ST_PIV;
            end else begin
              state_nxt = ST_ORD;
            end
          end
        end
      end
      ST_POP: begin
        if (sp_r == '0) begin
          state_nxt = ST_ORD;
        end else begin
          sp_nxt = sp_r - 1'b1;
          saddr = AddrW'(sp_r - 1'b1);
          state_nxt = ST_POPW;
        end
      end
      ST_POPW: begin
        lo_nxt = srd[StkW-1:AddrW];
        hi_nxt = srd[AddrW-1:0];
        state_nxt = ST_PIV;
      end
      ST_PIV: begin
        raddr = hi_r;
        nx_nxt = lo_r;
        i_nxt = lo_r;
        state_nxt = ST_RDI;
      end
      ST_RDI: begin
        if (i_r == lo_r) begin
          piv_nxt = rrd[15:0];
        end
        raddr = i_r;
        if (i_r == hi_r) begin
          raddr = nx_r;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (low_side) begin
          hold_nxt = rrd;
          raddr = nx_r;
          state_nxt = ST_SWN;
        end else begin
          i_nxt = i_r + 1'b1;
          raddr = i_nxt;
          state_nxt = ST_RDI;
        end
      end
      ST_SWN: begin
        raddr = i_r;
        rwe = 1'b1;
        rwd = rrd;
        hold_nxt = hold_r;
        // next cycle write hold to nx
        state_nxt = ST_FINW;
        pl_nxt = 1'b0;
      end
      ST_FIN: begin
        hold_nxt = rrd;
        raddr = hi_r;
        state_nxt = ST_FINW;
        pl_nxt = 1'b1;
      end
      ST_FINW: begin
        if (pl_r) begin
          raddr = nx_r;
          rwe = 1'b1;
          rwd = rrd;
          hi_nxt = hi_r;
          state_nxt = ST_PUSH;
          hold_nxt = hold_r;
        end else begin
          raddr = nx_r;
          rwe = 1'b1;
          rwd = hold_r;
          nx_nxt = nx_r + 1'b1;
          i_nxt = i_r + 1'b1;
          state_nxt = ST_RDI;
          raddr = nx_r;
        end
      end
      ST_PUSH: begin
        raddr = hi_r;
        rwe = ~ph_r;
        rwd = hold_r;
        ph_nxt = 1'b1;
        if (!ph_r) begin
          pl_nxt = 1'b0;
        end else if (!pl_r) begin
          pl_nxt = 1'b1;
          if ({1'b0, nx_r} > {1'b0, lo_r} + 1'b1) begin
            swe = 1'b1;
            swd = {lo_r, AddrW'(nx_r - 1'b1)};
            sp_nxt = sp_r + 1'b1;
          end
        end else begin
          ph_nxt = 1'b0;
          state_nxt = ST_POP;
          if ({1'b0, nx_r} + 1'b1 < {1'b0, hi_r}) begin
            swe = 1'b1;
            swd = {AddrW'(nx_r + 1'b1), hi_r};
            sp_nxt = sp_r + 1'b1;
          end
        end
      end
      ST_ORD: begin
        i_nxt = '0;
        raddr = '0;
        pl_nxt = 1'b0;
        state_nxt = (cnt_r == '0) ? ST_LOAD : ST_OUT;
        if (cnt_r == '0) begin
          ovf_nxt = 1'b0;
        end
      end
      ST_OUT: begin
        raddr = i_r;
        if (ov_r && out_tready) begin
          ov_nxt = 1'b0;
          if (ol_r) begin
            cnt_nxt = '0;
            ovf_nxt = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            i_nxt = i_r + 1'b1;
            raddr = i_nxt;
            pl_nxt = 1'b1;
          end
        end else if (!ov_r) begin
          if (pl_r) begin
            ov_nxt = 1'b1;
            od_nxt = rrd;
            ol_nxt = ({1'b0, i_r} + 1'b1) == cnt_r;
          end else begin
            pl_nxt = 1'b1;
          end
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end
endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// tb_top: self-checking testbench for record_quicksort_by_key_top, with a sorting predictor
// and random stimulus, random input valid gaps and random output back-pressure
// depends on rqs_pkg and the record_quicksort_by_key_top rtl
module tb_top
  import rqs_pkg::*;
();

  typedef struct {
    logic signed [15:0] key;
    logic [15:0]        tag;
    logic               last;
    logic               ovf;
  } sorted_rec_t;

  typedef struct {
    logic signed [15:0] key;
    logic [15:0]        tag;
    logic               last;
    logic               has_exp;
    logic signed [15:0] exp_key;
    logic [15:0]        exp_tag;
  } stim_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready, in_tlast;
  logic [31:0] in_tdata;
  logic out_tvalid, out_tready, out_tuser, out_tlast;
  logic [31:0] out_tdata;
  logic cfg_valid, cfg_ready, cfg_data;

  sorted_rec_t sorted_q[$];
  logic signed [15:0] p_key[MaxRecords];
  logic [15:0]        p_tag[MaxRecords];
  int unsigned        p_count;
  logic               p_ovf;
  logic               p_desc;
  int  errors;
  int  items_sent;
  bit  quiet;
  bit  hold_req;
  longint cycles;

  record_quicksort_by_key_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_top failed");
      $finish;
    end
  end

  function automatic void swap_rec(int unsigned i, int unsigned j);
    logic signed [15:0] k;
    logic [15:0] t;
    k = p_key[i];
    t = p_tag[i];
    p_key[i] = p_key[j];
    p_tag[i] = p_tag[j];
    p_key[j] = k;
    p_tag[j] = t;
  endfunction

  // lomuto quicksort with an explicit range stack, pivot is the range's last record
  function automatic void sort_records();
    int unsigned lo_s[MaxRecords];
    int unsigned hi_s[MaxRecords];
    int unsigned depth, lo, hi, nxt;
    logic signed [15:0] pivot;
    if (p_count < 2) return;
    lo_s[0] = 0;
    hi_s[0] = p_count - 1;
    depth = 1;
    while (depth > 0) begin
      depth--;
      lo = lo_s[depth];
      hi = hi_s[depth];
      pivot = p_key[hi];
      nxt = lo;
      for (int unsigned i = lo; i < hi; i++) begin
        if (p_desc ? (p_key[i] >= pivot) : (p_key[i] <= pivot)) begin
          swap_rec(nxt, i);
          nxt++;
        end
      end
      swap_rec(nxt, hi);
      if (nxt > lo + 1 && depth < MaxRecords) begin
        lo_s[depth] = lo;
        hi_s[depth] = nxt - 1;
        depth++;
      end
      if (nxt + 1 < hi && depth < MaxRecords) begin
        lo_s[depth] = nxt + 1;
        hi_s[depth] = hi;
        depth++;
      end
    end
  endfunction

  function automatic void predict_record(logic signed [15:0] key, logic [15:0] tag,
                                         logic last);
    sorted_rec_t r;
    if (p_count < MaxRecords) begin
      p_key[p_count] = key;
      p_tag[p_count] = tag;
      p_count++;
    end else begin
      p_ovf = 1'b1;
    end
    if (!last) return;
    sort_records();
    for (int unsigned i = 0; i < p_count; i++) begin
      r.key = p_key[i];
      r.tag = p_tag[i];
      r.last = (i + 1 == p_count);
      r.ovf = p_ovf;
      sorted_q.push_back(r);
    end
    p_count = 0;
    p_ovf = 1'b0;
  endfunction

  task automatic send_record(logic signed [15:0] key, logic [15:0] tag, logic last);
    int gap;
    in_tdata <= {tag, key};
    in_tlast <= last;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_record(key, tag, last);
    items_sent++;
    gap = quiet ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_order(logic desc);
    in_tvalid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_data <= desc;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    p_desc = desc;
  endtask

  // result side
  initial begin
    int stall;
    sorted_rec_t e;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_tready <= 1'b0;
        repeat (600) @(posedge clk);
      end
      stall = quiet ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      if (sorted_q.size() == 0) begin
        $error("unexpected result key %0d tag %0h", $signed(out_tdata[15:0]), out_tdata[31:16]);
        errors++;
      end else begin
        e = sorted_q.pop_front();
        if (out_tdata[15:0] !== e.key) begin
          $error("out_key expected %0d actual %0d", e.key, $signed(out_tdata[15:0]));
          errors++;
        end
        if (out_tdata[31:16] !== e.tag) begin
          $error("out_tag expected %0h actual %0h", e.tag, out_tdata[31:16]);
          errors++;
        end
        if (out_tlast !== e.last) begin
          $error("last_out expected %0b actual %0b", e.last, out_tlast);
          errors++;
        end
        if (out_tuser !== e.ovf) begin
          $error("overflow expected %0b actual %0b", e.ovf, out_tuser);
          errors++;
        end
      end
    end
  end

  stim_row_t directed[] = '{
    '{16'sh7fff, 16'hffff, 1'b1, 1'b1, 16'sh7fff, 16'hffff},
    '{-16'sh8000, 16'h0000, 1'b1, 1'b1, -16'sh8000, 16'h0000},
    '{16'sd0, 16'h0001, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{-16'sd1, 16'h0002, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sh7fff, 16'h0003, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{-16'sh8000, 16'h0004, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sd0, 16'h0005, 1'b1, 1'b0, 16'sd0, 16'h0},
    '{16'sd7, 16'h0010, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sd7, 16'h0011, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sd7, 16'h0012, 1'b1, 1'b0, 16'sd0, 16'h0},
    '{16'sd1, 16'haaaa, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sd2, 16'h5555, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sd3, 16'h8001, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sd4, 16'h7ffe, 1'b1, 1'b0, 16'sd0, 16'h0},
    '{16'sd9, 16'h0020, 1'b0, 1'b0, 16'sd0, 16'h0},
    '{16'sd5, 16'h0021, 1'b1, 1'b0, 16'sd0, 16'h0}
  };

  initial begin
    int set_no, set_size;
    logic signed [15:0] k;
    errors = 0;
    items_sent = 0;
    cycles = 0;
    quiet = 0;
    hold_req = 0;
    p_count = 0;
    p_ovf = 1'b0;
    p_desc = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) begin
      send_record(directed[i].key, directed[i].tag, directed[i].last);
      if (directed[i].has_exp) begin
        void'(sorted_q.pop_back());
        sorted_q.push_back('{directed[i].exp_key, directed[i].exp_tag, 1'b1, 1'b0});
      end
    end

    set_no = 0;
    while (items_sent < 210) begin
      if (set_no % 4 == 0) begin
        write_order(1'(set_no < 8 ? ((set_no / 4) == 0) : $urandom_range(0, 1)));
      end
      quiet = ($urandom_range(0, 3) == 0);
      if (set_no == 5) hold_req = 1;
      set_size = (set_no == 2) ? 64 + $urandom_range(1, 3)
               : (set_no == 6) ? 64 : $urandom_range(1, 12);
      for (int j = 0; j < set_size; j++) begin
        k = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 4) - 2) : 16'($urandom);
        send_record(k, 16'($urandom), j == set_size - 1);
      end
      set_no++;
    end
    in_tvalid <= 1'b0;
    quiet = 0;
    while (sorted_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end
endmodule

/* filelist.f */
hdl/rqs_pkg.sv
hdl/rqs_ram.sv
hdl/record_quicksort_by_key_top.sv
dv/tb_top.sv
